// ===== src/rhi_pkg.sv =====
// Shared constants and types for the RGB to HSV and intensity converter.
`timescale 1ns / 1ps
package rhi_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 8;
  localparam int unsigned IN_W            = 8;
  localparam int unsigned HUE_W           = 15;
  localparam int unsigned PCT_W           = 15;
  localparam int unsigned INT_W           = 16;

  localparam int unsigned HUE_FULL    = 23040;
  localparam int unsigned SECTOR_STEP = 3840;
  localparam int unsigned GREEN_BASE  = 7680;
  localparam int unsigned BLUE_BASE   = 15360;
  localparam int unsigned PCT_TWICE   = 51200;
  localparam int unsigned INT_MAX     = 65535;
  localparam int unsigned INT_DEN     = 6;
  localparam int unsigned INT_BIAS    = 3;

  typedef struct packed {
    logic hue_zero;
    logic sat_zero;
  } flags_t;

endpackage

// ===== src/rhi_front.sv =====
// Front stage: register the pixel, find max and min, build dividends and divisors.
`timescale 1ns / 1ps
module rhi_front #(
  parameter int unsigned SAMPLE_BITS = rhi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [rhi_pkg::IN_W-1:0]     red_i,
  input  logic [rhi_pkg::IN_W-1:0]     green_i,
  input  logic [rhi_pkg::IN_W-1:0]     blue_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [SAMPLE_BITS+16:0]      sat_num_o,
  output logic [SAMPLE_BITS+16:0]      bri_num_o,
  output logic [SAMPLE_BITS+16:0]      hue_num_o,
  output logic [SAMPLE_BITS+16:0]      int_num_o,
  output logic [SAMPLE_BITS:0]         sat_den_o,
  output logic [SAMPLE_BITS:0]         hue_den_o,
  output rhi_pkg::flags_t              flags_o
);

  localparam int unsigned W  = SAMPLE_BITS;
  localparam int unsigned NW = SAMPLE_BITS + 17;
  localparam logic [W-1:0] FS = {W{1'b1}};

  logic         valid_q, valid_d;
  logic [W-1:0] r_q, g_q, b_q;
  logic         load;

  logic [W-1:0]          mx, mn, d;
  logic signed [W:0]     diff;
  logic [rhi_pkg::HUE_W-1:0] base;
  logic [NW-1:0]         base_prod;
  logic signed [NW:0]    diff_s, step_s, hue_s;
  logic [NW-1:0]         hue_u;
  logic [W+1:0]          sum;

  assign stall_o = valid_q & full_i;
  assign push_o  = valid_q & ~full_i;
  assign load    = valid_i & ~stall_o;
  assign valid_d = load | (valid_q & full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      r_q <= W'(red_i);
      g_q <= W'(green_i);
      b_q <= W'(blue_i);
    end
  end

  always_comb begin
    mx = (r_q > g_q) ? r_q : g_q;
    mn = (r_q < g_q) ? r_q : g_q;
    if (b_q > mx) begin
      mx = b_q;
    end
    if (b_q < mn) begin
      mn = b_q;
    end
    d = mx - mn;

    if (mx == r_q) begin
      diff = $signed({1'b0, g_q}) - $signed({1'b0, b_q});
      base = (g_q >= b_q) ? '0 : rhi_pkg::HUE_W'(rhi_pkg::HUE_FULL);
    end else if (mx == g_q) begin
      diff = $signed({1'b0, b_q}) - $signed({1'b0, r_q});
      base = rhi_pkg::HUE_W'(rhi_pkg::GREEN_BASE);
    end else begin
      diff = $signed({1'b0, r_q}) - $signed({1'b0, g_q});
      base = rhi_pkg::HUE_W'(rhi_pkg::BLUE_BASE);
    end

    base_prod = NW'(base) * NW'(d);
    diff_s    = (NW+1)'(diff);
    step_s    = diff_s * $signed((NW+1)'(rhi_pkg::SECTOR_STEP));
    hue_s     = $signed({1'b0, base_prod}) + step_s;
    hue_u     = NW'($unsigned(hue_s));
    sum       = (W+2)'(r_q) + (W+2)'(g_q) + (W+2)'(b_q);
  end

  assign hue_num_o = {hue_u[NW-2:0], 1'b0} + NW'(d);
  assign hue_den_o = {d, 1'b0};
  assign sat_num_o = NW'(rhi_pkg::PCT_TWICE) * NW'(d) + NW'(mx);
  assign sat_den_o = {mx, 1'b0};
  assign bri_num_o = NW'(rhi_pkg::PCT_TWICE) * NW'(mx) + NW'(FS);
  assign int_num_o = NW'({sum, 9'd0}) + NW'(rhi_pkg::INT_BIAS);
  assign flags_o.hue_zero = (d == '0);
  assign flags_o.sat_zero = (mx == '0);

endmodule

// ===== src/rhi_queue.sv =====
// Two-entry queue between the front stage and the divider pipeline.
`timescale 1ns / 1ps
module rhi_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic [1:0]        count_q, count_d;
  logic              wr_q, rd_q;
  logic              do_pop;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/rhi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rhi_div #(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 9,
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned CW = DW + QW;
  localparam int unsigned RW = (NW > CW) ? NW : CW;

  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic [RW-1:0] rem_in, trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = RW'(den_in) << B;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_in - trial) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (take ? (QW'(1) << B) : '0);
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== src/rhi_back.sv =====
// Back end: divider pipelines, constant-divisor multipliers, result fix-up and output register.
`timescale 1ns / 1ps
module rhi_back #(
  parameter int unsigned SAMPLE_BITS = rhi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [SAMPLE_BITS+16:0]       sat_num_i,
  input  logic [SAMPLE_BITS+16:0]       bri_num_i,
  input  logic [SAMPLE_BITS+16:0]       hue_num_i,
  input  logic [SAMPLE_BITS+16:0]       int_num_i,
  input  logic [SAMPLE_BITS:0]          sat_den_i,
  input  logic [SAMPLE_BITS:0]          hue_den_i,
  input  rhi_pkg::flags_t               flags_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [rhi_pkg::HUE_W-1:0]     hue_o,
  output logic [rhi_pkg::PCT_W-1:0]     saturation_o,
  output logic [rhi_pkg::PCT_W-1:0]     brightness_o,
  output logic [rhi_pkg::INT_W-1:0]     intensity_o
);

  localparam int unsigned W  = SAMPLE_BITS;
  localparam int unsigned NW = SAMPLE_BITS + 17;
  localparam int unsigned DW = SAMPLE_BITS + 1;
  localparam int unsigned QW = (SAMPLE_BITS + 8 > 15) ? SAMPLE_BITS + 8 : 15;

  localparam int unsigned BRI_N  = W + 16;
  localparam int unsigned BRI_SH = 2 * W + 17;
  localparam int unsigned BRI_PW = 2 * BRI_N + 1;
  localparam longint unsigned BRI_DIV = 2 * ((64'd1 << W) - 1);
  localparam logic [BRI_N:0] BRI_MUL =
    (BRI_N+1)'(((64'd1 << BRI_SH) + BRI_DIV - 1) / BRI_DIV);
  localparam int unsigned INT_N  = W + 11;
  localparam int unsigned INT_SH = W + 14;
  localparam int unsigned INT_PW = 2 * INT_N + 1;
  localparam logic [INT_N:0] INT_MUL =
    (INT_N+1)'(((64'd1 << INT_SH) + rhi_pkg::INT_DEN - 1) / rhi_pkg::INT_DEN);

  logic                  en;
  logic [QW-1:0]         vld_q;
  rhi_pkg::flags_t       flg_q [QW];
  logic [QW-1:0]         sat_quo, bri_quo, hue_quo, int_quo;
  logic [QW-1:0]         hue_fix, int_fix;
  logic [BRI_PW-1:0]     bri_prod;
  logic [INT_PW-1:0]     int_prod;
  logic [QW-1:0]         bri_pipe_q [QW];
  logic [QW-1:0]         int_pipe_q [QW];
  logic                  out_valid_q;
  logic [rhi_pkg::HUE_W-1:0] hue_q;
  logic [rhi_pkg::PCT_W-1:0] sat_q, bri_q;
  logic [rhi_pkg::INT_W-1:0] int_q;

  assign en      = ~(out_valid_q & stall_i);
  assign ready_o = en;

  rhi_div #(.NW(NW), .DW(DW), .QW(QW)) u_sat_div (
    .clk_i(clk_i), .en_i(en), .num_i(sat_num_i), .den_i(sat_den_i), .quo_o(sat_quo)
  );
  rhi_div #(.NW(NW), .DW(DW), .QW(QW)) u_hue_div (
    .clk_i(clk_i), .en_i(en), .num_i(hue_num_i), .den_i(hue_den_i), .quo_o(hue_quo)
  );

  always_comb begin
    bri_prod = BRI_PW'(bri_num_i[BRI_N-1:0]) * BRI_PW'(BRI_MUL);
    int_prod = INT_PW'(int_num_i[INT_N-1:0]) * INT_PW'(INT_MUL);
  end

  assign bri_quo = bri_pipe_q[QW-1];
  assign int_quo = int_pipe_q[QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[QW-2:0], valid_i};
      out_valid_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flg_q[0]      <= flags_i;
      bri_pipe_q[0] <= QW'(bri_prod >> BRI_SH);
      int_pipe_q[0] <= QW'(int_prod >> INT_SH);
      for (int i = 1; i < QW; i++) begin
        flg_q[i]      <= flg_q[i-1];
        bri_pipe_q[i] <= bri_pipe_q[i-1];
        int_pipe_q[i] <= int_pipe_q[i-1];
      end
    end
  end

  always_comb begin
    if (flg_q[QW-1].hue_zero) begin
      hue_fix = '0;
    end else if (hue_quo >= QW'(rhi_pkg::HUE_FULL)) begin
      hue_fix = hue_quo - QW'(rhi_pkg::HUE_FULL);
    end else begin
      hue_fix = hue_quo;
    end
    int_fix = (int_quo > QW'(rhi_pkg::INT_MAX)) ? QW'(rhi_pkg::INT_MAX) : int_quo;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= rhi_pkg::HUE_W'(hue_fix);
      sat_q <= flg_q[QW-1].sat_zero ? '0 : rhi_pkg::PCT_W'(sat_quo);
      bri_q <= rhi_pkg::PCT_W'(bri_quo);
      int_q <= rhi_pkg::INT_W'(int_fix);
    end
  end

  assign valid_o      = out_valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;
  assign intensity_o  = int_q;

endmodule

// ===== src/rgb_to_hsv_intensity.sv =====
// Top level of the RGB to hue, saturation, value and intensity converter.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o   | red_i, green_i, blue_i
//   out     | output    | out_valid_o / out_stall_i | hue_o, saturation_o, brightness_o,
//           |           |                           | intensity_o
//
// One word per clock sustained while out_stall_i is low. The divider pipelines produce
// QW = max(15, SAMPLE_BITS + 8) quotient bits, one bit per stage.
// Reset clears the valid flags and the queue count and pointers only; no clearing pass.
// An output stall holds the divider pipelines while out_valid_o is high; the two-entry
// queue absorbs the front stage, and in_stall_o rises only when the queue is full.
`timescale 1ns / 1ps
module rgb_to_hsv_intensity #(
  parameter int unsigned SAMPLE_BITS = rhi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rhi_pkg::IN_W-1:0]      red_i,
  input  logic [rhi_pkg::IN_W-1:0]      green_i,
  input  logic [rhi_pkg::IN_W-1:0]      blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rhi_pkg::HUE_W-1:0]     hue_o,
  output logic [rhi_pkg::PCT_W-1:0]     saturation_o,
  output logic [rhi_pkg::PCT_W-1:0]     brightness_o,
  output logic [rhi_pkg::INT_W-1:0]     intensity_o
);

  localparam int unsigned NW = SAMPLE_BITS + 17;
  localparam int unsigned DW = SAMPLE_BITS + 1;
  localparam int unsigned EW = 4 * NW + 2 * DW + $bits(rhi_pkg::flags_t);

  logic            push, full, q_valid, back_ready;
  logic [NW-1:0]   f_sat_num, f_bri_num, f_hue_num, f_int_num;
  logic [DW-1:0]   f_sat_den, f_hue_den;
  rhi_pkg::flags_t f_flags;
  logic [NW-1:0]   b_sat_num, b_bri_num, b_hue_num, b_int_num;
  logic [DW-1:0]   b_sat_den, b_hue_den;
  rhi_pkg::flags_t b_flags;
  logic [EW-1:0]   q_in, q_out;

  rhi_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .full_i   (full),
    .push_o   (push),
    .sat_num_o(f_sat_num),
    .bri_num_o(f_bri_num),
    .hue_num_o(f_hue_num),
    .int_num_o(f_int_num),
    .sat_den_o(f_sat_den),
    .hue_den_o(f_hue_den),
    .flags_o  (f_flags)
  );

  assign q_in = {f_sat_num, f_bri_num, f_hue_num, f_int_num, f_sat_den, f_hue_den, f_flags};

  rhi_queue #(.DATA_W(EW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (back_ready),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  assign {b_sat_num, b_bri_num, b_hue_num, b_int_num, b_sat_den, b_hue_den, b_flags} = q_out;

  rhi_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .ready_o     (back_ready),
    .sat_num_i   (b_sat_num),
    .bri_num_i   (b_bri_num),
    .hue_num_i   (b_hue_num),
    .int_num_i   (b_int_num),
    .sat_den_i   (b_sat_den),
    .hue_den_i   (b_hue_den),
    .flags_i     (b_flags),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o),
    .intensity_o (intensity_o)
  );

endmodule
